FILE: rtl/core/ibp_pkg.sv
// Shared types for the interval batch partitioner: the stored interval entry,
// the controller command word and the sort order. No dependencies.
package ibp_pkg;

    localparam int STATE_W     = 8;
    localparam int TIME_W      = 32;
    localparam int BATCH_NUM_W = 3;
    localparam int USED_W      = 4;

    typedef struct packed {
        logic [STATE_W-1:0]       si;
        logic signed [TIME_W-1:0] st;
        logic signed [TIME_W-1:0] en;
    } entry_t;

    typedef struct packed {
        logic load;
        logic sort;
        logic sort_odd;
        logic check;
        logic scan;
        logic decide;
        logic emit;
    } cmd_t;

    // true if a belongs after b: state, then start, then end (signed)
    function automatic logic sorts_after(entry_t a, entry_t b);
        logic res;
        if (a.si != b.si)
        begin
            res = (a.si > b.si);
        end
        else if (a.st != b.st)
        begin
            res = ($signed(a.st) > $signed(b.st));
        end
        else
        begin
            res = ($signed(a.en) > $signed(b.en));
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/ibp_store.sv
// Interval store: register row that loads, sorts by odd-even transposition,
// checks overlap, rotates for tagging, shifts out to emit. Depends on ibp_pkg.
module ibp_store
    import ibp_pkg::*;
#(
    parameter int MAX_CUTS = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic [$clog2(MAX_CUTS)-1:0]   wr_idx,
    input  logic [$clog2(MAX_CUTS+1)-1:0] n,
    input  entry_t                        din,
    input  logic [BATCH_NUM_W-1:0]        tag_batch,
    input  logic                          tag_drop,
    output entry_t                        head,
    output logic                          overlap,
    output logic [STATE_W-1:0]            out_state_index,
    output logic signed [TIME_W-1:0]      out_start_ms,
    output logic signed [TIME_W-1:0]      out_end_ms,
    output logic [BATCH_NUM_W-1:0]        batch_number,
    output logic                          dropped
);

    localparam int IW = $clog2(MAX_CUTS);
    localparam int CW = $clog2(MAX_CUTS+1);

    entry_t                 ent_reg  [MAX_CUTS];
    entry_t                 ent_next [MAX_CUTS];
    logic [BATCH_NUM_W-1:0] tb_reg   [MAX_CUTS];
    logic [BATCH_NUM_W-1:0] tb_next  [MAX_CUTS];
    logic                   td_reg   [MAX_CUTS];
    logic                   td_next  [MAX_CUTS];
    logic                   overlap_reg;
    logic                   overlap_next;
    logic [CW-1:0]          n_m1;
    logic [IW-1:0]          last_idx;

    logic [STATE_W-1:0]       o_si_reg;
    logic signed [TIME_W-1:0] o_st_reg;
    logic signed [TIME_W-1:0] o_en_reg;
    logic [BATCH_NUM_W-1:0]   o_tb_reg;
    logic                     o_td_reg;

    assign n_m1     = n - CW'(1);
    assign last_idx = n_m1[IW-1:0];

    always_comb
    begin
        for (int j = 0; j < MAX_CUTS; j++)
        begin
            ent_next[j] = ent_reg[j];
            tb_next[j]  = tb_reg[j];
            td_next[j]  = td_reg[j];
        end
        overlap_next = overlap_reg;

        if (cmd.load)
        begin
            ent_next[wr_idx] = din;
        end

        if (cmd.sort)
        begin
            // pairs of one parity are disjoint, so all exchanges are independent
            for (int j = 0; j < MAX_CUTS-1; j++)
            begin
                if ((((j % 2) == 1) == cmd.sort_odd) && (CW'(j+1) < n) &&
                    sorts_after(ent_reg[j], ent_reg[j+1]))
                begin
                    ent_next[j]   = ent_reg[j+1];
                    ent_next[j+1] = ent_reg[j];
                end
            end
        end

        if (cmd.check)
        begin
            overlap_next = 1'b0;
            for (int j = 0; j < MAX_CUTS-1; j++)
            begin
                if ((CW'(j+1) < n) && (ent_reg[j].si == ent_reg[j+1].si) &&
                    ($signed(ent_reg[j+1].st) < $signed(ent_reg[j].en)))
                begin
                    overlap_next = 1'b1;
                end
            end
        end

        if (cmd.decide || cmd.emit)
        begin
            for (int j = 0; j < MAX_CUTS-1; j++)
            begin
                ent_next[j] = ent_reg[j+1];
                tb_next[j]  = tb_reg[j+1];
                td_next[j]  = td_reg[j+1];
            end
        end

        // rotate the tagged head round to the tail of the set
        if (cmd.decide)
        begin
            ent_next[last_idx] = ent_reg[0];
            tb_next[last_idx]  = tag_batch;
            td_next[last_idx]  = tag_drop;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_CUTS; j++)
        begin
            ent_reg[j] <= ent_next[j];
            tb_reg[j]  <= tb_next[j];
            td_reg[j]  <= td_next[j];
        end
        if (cmd.emit)
        begin
            o_si_reg <= ent_reg[0].si;
            o_st_reg <= ent_reg[0].st;
            o_en_reg <= ent_reg[0].en;
            o_tb_reg <= tb_reg[0];
            o_td_reg <= td_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_reg <= 1'b0;
        end
        else
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign head            = ent_reg[0];
    assign overlap         = overlap_reg;
    assign out_state_index = o_si_reg;
    assign out_start_ms    = o_st_reg;
    assign out_end_ms      = o_en_reg;
    assign batch_number    = o_tb_reg;
    assign dropped         = o_td_reg;

endmodule

FILE: rtl/core/ibp_batch.sv
// Batch tracker: last end time per open batch in a small memory, a serial
// minimum scan and the join/open/drop decision. Depends on ibp_pkg.
module ibp_batch
    import ibp_pkg::*;
#(
    parameter int MAX_BATCHES = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cmd_t                               cmd,
    input  logic [$clog2(MAX_BATCHES+1)-1:0]   k,
    input  logic                               overlap,
    input  logic signed [TIME_W-1:0]           head_start,
    input  logic signed [TIME_W-1:0]           head_end,
    output logic [BATCH_NUM_W-1:0]             tag_batch,
    output logic                               tag_drop,
    output logic [$clog2(MAX_BATCHES+1)-1:0]   open_count
);

    localparam int BW = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
    localparam int OW = $clog2(MAX_BATCHES+1);

    logic signed [TIME_W-1:0] end_mem [MAX_BATCHES];
    logic signed [TIME_W-1:0] rd_reg;
    logic signed [TIME_W-1:0] best_end_reg;
    logic [BW-1:0]            best_reg;
    logic                     have_reg;
    logic [OW-1:0]            open_reg;
    logic [OW-1:0]            open_next;
    logic [OW-1:0]            k_m1;
    logic                     wr_en;
    logic [BW-1:0]            wr_addr;
    logic [BW-1:0]            pick;
    logic [BW+BATCH_NUM_W-1:0] pick_ext;

    assign k_m1 = k - OW'(1);

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = best_reg;
        pick      = '0;
        tag_drop  = 1'b0;
        open_next = open_reg;
        if (cmd.check)
        begin
            open_next = '0;
        end
        else if (cmd.decide && overlap)
        begin
            if (have_reg && (head_start >= best_end_reg))
            begin
                wr_en = 1'b1;
                pick  = best_reg;
            end
            else if (open_reg < OW'(MAX_BATCHES))
            begin
                wr_en     = 1'b1;
                wr_addr   = open_reg[BW-1:0];
                pick      = open_reg[BW-1:0];
                open_next = open_reg + OW'(1);
            end
            else
            begin
                tag_drop = 1'b1;
            end
        end
    end

    assign pick_ext  = {{BATCH_NUM_W{1'b0}}, pick};
    assign tag_batch = pick_ext[BATCH_NUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            end_mem[wr_addr] <= head_end;
        end
        if (cmd.scan && (k < open_reg))
        begin
            rd_reg <= end_mem[k[BW-1:0]];
        end
        // read data is registered and holds the entry at the previous address: compare entry k-1
        if (cmd.scan && (k != '0) && (!have_reg || (rd_reg < best_end_reg)))
        begin
            best_reg     <= k_m1[BW-1:0];
            best_end_reg <= rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
            if (cmd.scan)
            begin
                have_reg <= (k != '0);
            end
        end
    end

    assign open_count = open_reg;

endmodule

FILE: rtl/core/ibp_ctrl.sv
// Controller for the interval batch partitioner: load count, sort passes,
// per-interval scan and decide, emission. Depends on ibp_pkg.
module ibp_ctrl
    import ibp_pkg::*;
#(
    parameter int MAX_CUTS    = 64,
    parameter int MAX_BATCHES = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             final_item,
    input  logic                             overlap,
    input  logic [$clog2(MAX_BATCHES+1)-1:0] open_count,
    output logic                             busy,
    output cmd_t                             cmd,
    output logic [$clog2(MAX_CUTS)-1:0]      wr_idx,
    output logic [$clog2(MAX_CUTS+1)-1:0]    n,
    output logic [$clog2(MAX_BATCHES+1)-1:0] k,
    output logic                             result_valid,
    output logic                             last_result
);

    localparam int IW = $clog2(MAX_CUTS);
    localparam int CW = $clog2(MAX_CUTS+1);
    localparam int OW = $clog2(MAX_BATCHES+1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pass_reg,  pass_next;
    logic [CW-1:0] item_reg,  item_next;
    logic [OW-1:0] k_reg,     k_next;
    logic          valid_reg, valid_next;
    logic          last_reg,  last_next;
    logic          accept;
    logic          has_room;
    logic          at_last;

    assign accept   = start && (state_reg == S_LOAD);
    assign has_room = (count_reg < CW'(MAX_CUTS));
    assign at_last  = (item_reg == (count_reg - CW'(1)));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        item_next  = item_reg;
        k_next     = k_reg;
        valid_next = 1'b0;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.load = has_room;
                    if (has_room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (final_item)
                    begin
                        pass_next  = '0;
                        state_next = S_SORT;
                    end
                end
            end
            S_SORT:
            begin
                cmd.sort     = 1'b1;
                cmd.sort_odd = pass_reg[0];
                pass_next    = pass_reg + CW'(1);
                if (pass_reg == (count_reg - CW'(1)))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                item_next  = '0;
                k_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                k_next   = k_reg + OW'(1);
                if (!overlap || (k_reg == open_count))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                k_next     = '0;
                if (at_last)
                begin
                    item_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    item_next  = item_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                valid_next = 1'b1;
                last_next  = at_last;
                item_next  = item_reg + CW'(1);
                if (at_last)
                begin
                    count_next = '0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            pass_reg  <= '0;
            item_reg  <= '0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pass_reg  <= pass_next;
            item_reg  <= item_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    assign busy         = (state_reg != S_LOAD);
    assign wr_idx       = count_reg[IW-1:0];
    assign n            = count_reg;
    assign k            = k_reg;
    assign result_valid = valid_reg;
    assign last_result  = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_CUTS))
        else $error("interval count beyond store depth");

    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && final_item) |=> busy)
        else $error("final transaction did not start processing");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (count_reg != '0) && (item_reg < count_reg))
        else $error("emission outside the loaded set");

endmodule

FILE: rtl/core/interval_batch_partitioner_top.sv
// Interval batch partitioner: loads intervals, sorts them, assigns batches by
// greedy interval partitioning and emits them. Depends on ibp_pkg, ibp_ctrl,
// ibp_store and ibp_batch.
//
// Intervals load one per cycle while busy is low; the transaction with
// final_item set closes the set (an interval beyond MAX_CUTS is ignored, its
// final_item still counts). Processing of n intervals then takes n sort passes
// of the odd-even transposition row, an overlap check, and per interval a
// serial scan of the batch end memory, then a decide step; the scan walks
// every open batch on an overlap and stops at once otherwise. Results leave
// on consecutive cycles, one per interval in sorted order, each for a single
// cycle under result_valid; the receiver cannot stall them. busy falls as
// the final result is registered, so a new set may load while it is shown.
module interval_batch_partitioner_top
    import ibp_pkg::*;
#(
    parameter int MAX_CUTS    = 64,
    parameter int MAX_BATCHES = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [STATE_W-1:0]       state_index,
    input  logic signed [TIME_W-1:0] start_ms,
    input  logic signed [TIME_W-1:0] end_ms,
    input  logic                     final_item,
    output logic                     result_valid,
    output logic [STATE_W-1:0]       out_state_index,
    output logic signed [TIME_W-1:0] out_start_ms,
    output logic signed [TIME_W-1:0] out_end_ms,
    output logic [BATCH_NUM_W-1:0]   batch_number,
    output logic                     dropped,
    output logic [USED_W-1:0]        batches_used,
    output logic                     last_result
);

    localparam int IW = $clog2(MAX_CUTS);
    localparam int CW = $clog2(MAX_CUTS+1);
    localparam int OW = $clog2(MAX_BATCHES+1);

    cmd_t                   cmd;
    logic [IW-1:0]          wr_idx;
    logic [CW-1:0]          n;
    logic [OW-1:0]          k;
    logic [OW-1:0]          open_count;
    logic                   overlap;
    entry_t                 din;
    entry_t                 head;
    logic [BATCH_NUM_W-1:0] tag_batch;
    logic                   tag_drop;
    logic [OW+USED_W-1:0]   used_ext;

    assign din.si = state_index;
    assign din.st = start_ms;
    assign din.en = end_ms;

    ibp_ctrl #(
        .MAX_CUTS    (MAX_CUTS),
        .MAX_BATCHES (MAX_BATCHES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .final_item   (final_item),
        .overlap      (overlap),
        .open_count   (open_count),
        .busy         (busy),
        .cmd          (cmd),
        .wr_idx       (wr_idx),
        .n            (n),
        .k            (k),
        .result_valid (result_valid),
        .last_result  (last_result)
    );

    ibp_store #(
        .MAX_CUTS (MAX_CUTS)
    ) u_store (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .wr_idx          (wr_idx),
        .n               (n),
        .din             (din),
        .tag_batch       (tag_batch),
        .tag_drop        (tag_drop),
        .head            (head),
        .overlap         (overlap),
        .out_state_index (out_state_index),
        .out_start_ms    (out_start_ms),
        .out_end_ms      (out_end_ms),
        .batch_number    (batch_number),
        .dropped         (dropped)
    );

    ibp_batch #(
        .MAX_BATCHES (MAX_BATCHES)
    ) u_batch (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .k          (k),
        .overlap    (overlap),
        .head_start (head.st),
        .head_end   (head.en),
        .tag_batch  (tag_batch),
        .tag_drop   (tag_drop),
        .open_count (open_count)
    );

    // without an overlap everything sits in one batch
    assign used_ext     = overlap ? {{USED_W{1'b0}}, open_count} : (OW+USED_W)'(1);
    assign batches_used = used_ext[USED_W-1:0];

endmodule

FILE: bench/ibp_checker.sv
`timescale 1ns / 100ps
// Checker for the interval batch partitioner: watches accepted intervals,
// predicts sorted, batched results and compares them. Depends on ibp_pkg.
module ibp_checker
    import ibp_pkg::*;
#(
    parameter int MAX_CUTS    = 64,
    parameter int MAX_BATCHES = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [STATE_W-1:0]       state_index,
    input  logic signed [TIME_W-1:0] start_ms,
    input  logic signed [TIME_W-1:0] end_ms,
    input  logic                     final_item,
    input  logic                     result_valid,
    input  logic [STATE_W-1:0]       out_state_index,
    input  logic signed [TIME_W-1:0] out_start_ms,
    input  logic signed [TIME_W-1:0] out_end_ms,
    input  logic [BATCH_NUM_W-1:0]   batch_number,
    input  logic                     dropped,
    input  logic [USED_W-1:0]        batches_used,
    input  logic                     last_result,
    output int                       fail_count,
    output int                       pending_count
);

    typedef struct {
        logic [STATE_W-1:0]       si;
        logic signed [TIME_W-1:0] st;
        logic signed [TIME_W-1:0] en;
        logic [BATCH_NUM_W-1:0]   batch;
        logic                     drop;
        logic [USED_W-1:0]        used;
        logic                     last;
    } placement_t;

    entry_t     held[$];
    placement_t placements[$];

    function automatic bit belongs_after(entry_t a, entry_t b);
        if (a.si != b.si)
            return a.si > b.si;
        if (a.st != b.st)
            return a.st > b.st;
        return a.en > b.en;
    endfunction

    task automatic partition_set();
        entry_t                   e;
        entry_t                   srt[$];
        logic signed [TIME_W-1:0] last_end[MAX_BATCHES];
        int                       open;
        int                       best;
        bit                       overlap;
        int                       j;
        placement_t               p;
        placement_t               batch_q[$];
        begin
            srt = held;
            for (int i = 1; i < srt.size(); i++)
            begin
                j = i;
                while (j > 0 && belongs_after(srt[j-1], srt[j]))
                begin
                    e = srt[j-1]; srt[j-1] = srt[j]; srt[j] = e;
                    j--;
                end
            end
            overlap = 0;
            for (int i = 1; i < srt.size(); i++)
                if (srt[i].si == srt[i-1].si && srt[i].st < srt[i-1].en)
                    overlap = 1;
            open = 0;
            foreach (srt[i])
            begin
                p.si = srt[i].si; p.st = srt[i].st; p.en = srt[i].en;
                p.batch = '0; p.drop = 0;
                p.last = (i == srt.size() - 1);
                if (overlap)
                begin
                    best = 0;
                    for (int d = 1; d < open; d++)
                        if (last_end[d] < last_end[best])
                            best = d;
                    if (open > 0 && srt[i].st >= last_end[best])
                    begin
                        p.batch = best[BATCH_NUM_W-1:0];
                        last_end[best] = srt[i].en;
                    end
                    else if (open < MAX_BATCHES)
                    begin
                        p.batch = open[BATCH_NUM_W-1:0];
                        last_end[open] = srt[i].en;
                        open++;
                    end
                    else
                        p.drop = 1;
                end
                batch_q.push_back(p);
            end
            foreach (batch_q[i])
            begin
                batch_q[i].used = overlap ? open[USED_W-1:0] : USED_W'(1);
                placements.push_back(batch_q[i]);
            end
            held.delete();
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        begin
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                     want);
            fail_count++;
        end
    endtask

    initial fail_count = 0;
    initial pending_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (placements.size() == 0)
                begin
                    $display("%0t: result with none expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    placement_t w;
                    w = placements.pop_front();
                    if (out_state_index !== w.si) report("out_state_index", out_state_index, w.si);
                    if (out_start_ms !== w.st) report("out_start_ms", out_start_ms, w.st);
                    if (out_end_ms !== w.en) report("out_end_ms", out_end_ms, w.en);
                    if (batch_number !== w.batch) report("batch_number", batch_number, w.batch);
                    if (dropped !== w.drop) report("dropped", dropped, w.drop);
                    if (batches_used !== w.used) report("batches_used", batches_used, w.used);
                    if (last_result !== w.last) report("last_result", last_result, w.last);
                end
            end
            if (start && !busy)
            begin
                if (held.size() < MAX_CUTS)
                    held.push_back('{si: state_index, st: start_ms, en: end_ms});
                if (final_item)
                    partition_set();
            end
        end
        pending_count = placements.size();
    end

endmodule

FILE: bench/tb_interval_batch_partitioner_top.sv
`timescale 1ns / 100ps
// Testbench top for the interval batch partitioner: drives interval sets and
// gives the verdict. Depends on ibp_pkg, ibp_checker and the block itself.
module tb_interval_batch_partitioner_top;
    import ibp_pkg::*;

    localparam int LIMIT = 400000;

    logic                     clk = 0;
    logic                     rst_n = 0;
    logic                     start = 0;
    logic                     busy;
    logic [STATE_W-1:0]       state_index = '0;
    logic signed [TIME_W-1:0] start_ms = '0;
    logic signed [TIME_W-1:0] end_ms = '0;
    logic                     final_item = 0;
    logic                     result_valid;
    logic [STATE_W-1:0]       out_state_index;
    logic signed [TIME_W-1:0] out_start_ms;
    logic signed [TIME_W-1:0] out_end_ms;
    logic [BATCH_NUM_W-1:0]   batch_number;
    logic                     dropped;
    logic [USED_W-1:0]        batches_used;
    logic                     last_result;
    int                       fail_count;
    int                       pending_count;
    int                       cycles = 0;

    always #5 clk = ~clk;

    interval_batch_partitioner_top dut (.*);
    ibp_checker chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_interval_batch_partitioner_top failed");
            $finish;
        end
    end

    // hold one interval until it is accepted, then sometimes drop start for a gap
    task automatic send(logic [7:0] si, logic [31:0] st, logic [31:0] en, logic fin);
        begin
            start       <= 1;
            state_index <= si;
            start_ms    <= st;
            end_ms      <= en;
            final_item  <= fin;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                start <= 0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
                    @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] pick_time(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_fffc + $urandom_range(0, 3);
            default: return $urandom_range(0, 60) - 30;
        endcase
    endfunction

    task automatic random_set(int n, int mode);
        logic [7:0]  si;
        logic [31:0] st;
        begin
            for (int i = 0; i < n; i++)
            begin
                si = (mode == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
                st = pick_time(mode == 0 ? $urandom_range(0, 3) : 3);
                send(si, st, (mode == 2) ? st + $urandom_range(0, 20) :
                     pick_time(mode == 0 ? $urandom_range(0, 3) : 3), i == n - 1);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // single interval, extremes
        send(8'hff, 32'h8000_0000, 32'h7fff_ffff, 1);
        // no overlap: everything in batch 0
        send(8'd1, 32'd0, 32'd10, 0);
        send(8'd1, 32'd10, 32'd20, 0);
        send(8'd0, 32'd5, 32'd6, 1);
        // overlap with equal ends and a largest end time
        send(8'd0, 32'd0, 32'h7fff_ffff, 0);
        send(8'd0, 32'd1, 32'd5, 0);
        send(8'd0, 32'd2, 32'd5, 0);
        send(8'd0, 32'd5, 32'd9, 0);
        send(8'd0, 32'h7fff_ffff, 32'h7fff_ffff, 1);
        // ten overlapping intervals: last two dropped
        for (int i = 0; i < 10; i++)
            send(8'd3, 32'd0, 32'd100, i == 9);
        // overfill the store; final flag on an ignored interval
        for (int i = 0; i < 66; i++)
            send(8'($urandom_range(0, 1)), 32'(i), 32'(i + 3), i == 65);
        for (int k = 0; k < 40; k++)
            random_set($urandom_range(1, 10), $urandom_range(0, 2));
        start <= 0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_interval_batch_partitioner_top passed");
        else
            $display("tb_interval_batch_partitioner_top failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ibp_pkg.sv
rtl/core/ibp_store.sv
rtl/core/ibp_batch.sv
rtl/core/ibp_ctrl.sv
rtl/core/interval_batch_partitioner_top.sv
bench/ibp_checker.sv
bench/tb_interval_batch_partitioner_top.sv
